>>> rtl/swe_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window extreme package
// Shared types and constants for the sliding window minimum/maximum unit.
// ----------------------------------------------------------------------------
package swe_pkg;

   // Configuration register indexes and widths.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SELECT_MAX = 1'b1;
   localparam logic [CSR_DATA_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // take a request, apply restart, read the front slot
      logic front_pop;    // drop the front entry, read the new front slot
      logic front_keep;   // keep the front value, read the back slot
      logic back_pop;     // drop the back entry, read the slot before it
      logic push;         // append the sample and deliver any result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;        // deque holds no entries
      logic expired;      // front entry read last has left the window
      logic supersede;    // back entry read last is superseded by the sample
      logic out_free;     // output register can take a result this cycle
   } status_type;

endpackage

>>> rtl/swe_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window extreme controller
// Sequences the front drops, back drops and the push of one sample.
// ----------------------------------------------------------------------------
module swe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  swe_pkg::status_type status,
   output swe_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      FRONT,
      BACK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = FRONT;
            end
         end
         FRONT: begin
            if (!status.empty && status.expired) begin
               cmd.front_pop = 1'b1;
            end else begin
               cmd.front_keep = 1'b1;
               state_in = BACK;
            end
         end
         BACK: begin
            if (!status.empty && status.supersede) begin
               cmd.back_pop = 1'b1;
            end else if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

>>> rtl/swe_datapath.sv
// ----------------------------------------------------------------------------
// Sliding window extreme datapath
// Deque memory, pointers, counters, configuration and the output register.
// ----------------------------------------------------------------------------
module swe_datapath #(
   parameter int WINDOW_MAX = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [swe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [swe_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   input  logic                                 req_restart,
   input  swe_pkg::cmd_type                     cmd,
   output swe_pkg::status_type                  status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [SAMPLE_WIDTH-1:0]              rsp_value
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int PW = $clog2(2 * WINDOW_MAX);
   localparam logic [PW-1:0] POS_LAST = PW'(2 * WINDOW_MAX - 1);
   localparam logic [PW:0] POS_MOD = (PW + 1)'(2 * WINDOW_MAX);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic [PW-1:0]                  position;
   } entry_type;

   // Deque storage.
   entry_type mem [WINDOW_MAX];
   entry_type rd_ff;

   // Configuration registers.
   logic [swe_pkg::CSR_DATA_WIDTH-1:0] window_size_ff;
   logic                               select_max_ff;

   // Sequence state.
   logic [AW-1:0] head_ff;
   logic [CW-1:0] count_ff;
   logic [PW-1:0] pos_ff;
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] k_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] front_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_value_ff;

   // Working signals.
   logic [CW-1:0] k_eff;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [AW-1:0] push_addr;
   logic [PW:0]   age;
   logic [CW-1:0] fill_clamped;
   logic [CW-1:0] fill_next;
   logic signed [SAMPLE_WIDTH-1:0] front_next;
   logic [CW-1:0] back_off;

   // Ring slot at an offset from the head, modulo the deque depth.
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                          input logic [CW-1:0] off);
      logic [31:0] s;
      s = 32'(head) + 32'(off);
      if (s >= 32'(WINDOW_MAX)) begin
         s = s - 32'(WINDOW_MAX);
      end
      return s[AW-1:0];
   endfunction

   // Effective window: zero counts as one, large values saturate.
   always_comb begin
      logic [31:0] ws;
      ws = 32'(window_size_ff);
      if (ws == 32'd0) begin
         ws = 32'd1;
      end else if (ws > 32'(WINDOW_MAX)) begin
         ws = 32'(WINDOW_MAX);
      end
      k_eff = ws[CW-1:0];
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swe_pkg::WINDOW_SIZE_RESET;
         select_max_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            swe_pkg::CSR_WINDOW_SIZE: window_size_ff <= csr_wdata;
            swe_pkg::CSR_SELECT_MAX:  select_max_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Read address for the next deque access.
   always_comb begin
      back_off = (count_ff >= CW'(2)) ? (count_ff - CW'(2)) : '0;
      rd_en = cmd.load | cmd.front_pop | cmd.front_keep | cmd.back_pop;
      if (cmd.front_pop) begin
         rd_addr = slot(head_ff, CW'(1));
      end else if (cmd.front_keep) begin
         rd_addr = slot(head_ff, count_ff - CW'(1));
      end else if (cmd.back_pop) begin
         rd_addr = slot(head_ff, back_off);
      end else begin
         rd_addr = head_ff;
      end
      push_addr = slot(head_ff, count_ff);
   end

   // Age of the front entry, modulo twice the largest window.
   always_comb begin
      if (pos_ff >= rd_ff.position) begin
         age = {1'b0, pos_ff} - {1'b0, rd_ff.position};
      end else begin
         age = {1'b0, pos_ff} + POS_MOD - {1'b0, rd_ff.position};
      end
   end

   // Status toward the controller.
   always_comb begin
      status.empty = (count_ff == '0);
      status.expired = (32'(age) >= 32'(k_ff));
      if (select_max_ff) begin
         status.supersede = (rd_ff.value <= sample_ff);
      end else begin
         status.supersede = (rd_ff.value >= sample_ff);
      end
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   // Fill count and front value after the push.
   always_comb begin
      fill_clamped = (fill_ff > k_ff) ? k_ff : fill_ff;
      fill_next = (fill_clamped < k_ff) ? (fill_clamped + CW'(1)) : fill_clamped;
      front_next = (count_ff == '0) ? sample_ff : front_ff;
   end

   // Deque memory: one write and one registered read.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[push_addr] <= '{value: sample_ff, position: pos_ff};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Request payload and front value.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         k_ff <= k_eff;
      end
      if (cmd.front_keep) begin
         front_ff <= rd_ff.value;
      end
      if (cmd.push) begin
         front_ff <= front_next;
      end
   end

   // Pointers and counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         pos_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.load && req_restart) begin
            head_ff <= '0;
            count_ff <= '0;
            pos_ff <= '0;
            fill_ff <= '0;
         end
         if (cmd.front_pop) begin
            head_ff <= slot(head_ff, CW'(1));
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.back_pop) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.push) begin
            count_ff <= count_ff + CW'(1);
            pos_ff <= (pos_ff == POS_LAST) ? '0 : (pos_ff + PW'(1));
            fill_ff <= fill_next;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push && (fill_next >= k_ff)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_value_ff <= front_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

>>> rtl/sliding_window_extreme_unit.sv
// ----------------------------------------------------------------------------
// Sliding window extreme unit
// Sliding-window minimum or maximum of a signed sample stream by monotonic deque.
// ----------------------------------------------------------------------------
// Each request carries one sample and a restart flag. The unit drops expired
// entries from the deque front, drops superseded entries from the back and
// appends the sample; once window_size samples of the current sequence have
// arrived, every request yields one response with the window minimum
// (select_max = 0) or maximum (select_max = 1). A request spends one deque
// step on each entry dropped from the front or back, and every sample is
// pushed once and dropped at most once (a restart clears the deque as its
// request is taken). Each deque step is gated by the registered read of the
// deque memory. A new request is taken only once the previous sample is
// pushed, but also while an earlier response waits in the output register;
// its push waits until that register is free. Configuration is to be written
// only while the unit is idle; the unit itself does not enforce this.
module sliding_window_extreme_unit #(
   parameter int WINDOW_MAX = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   // Configuration port.
   input  logic                                csr_we,
   input  logic [swe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [swe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   // Request channel.
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]     req_tdata,  // sample
   input  logic                                          req_tuser,  // restart
   // Response channel.
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]     rsp_tdata   // extreme_value
);

   localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   swe_pkg::cmd_type    cmd;
   swe_pkg::status_type status;
   logic [SAMPLE_WIDTH-1:0] rsp_value;

   swe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swe_datapath #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_sample  ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .req_restart (req_tuser),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_value   (rsp_value)
   );

   // Response data, zero padded to whole bytes.
   assign rsp_tdata = DATA_W'(rsp_value);

endmodule
